// ===== rtl/core/qrgd_pkg.sv =====
// Shared constants and types for the quadrature rotation gesture detector.
package qrgd_pkg;

    localparam int POSITION_BITS     = 16;
    localparam int COUNT_BITS        = 8;
    localparam int AGE_BITS          = 8;
    localparam int CFG_DATA_BITS     = 8;
    localparam int CFG_INDEX_BITS    = 1;
    localparam int POSITION_OUT_BITS = 16;

    // Width that holds a saturating count plus a full position step.
    localparam int SUM_BITS = ((POSITION_BITS > COUNT_BITS) ? POSITION_BITS : COUNT_BITS) + 1;
    // Width for comparing a count with the threshold register.
    localparam int CMP_BITS = (COUNT_BITS > CFG_DATA_BITS) ? COUNT_BITS : CFG_DATA_BITS;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [AGE_BITS-1:0]   AGE_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_POLLS   = 1'b1;

    localparam logic [CFG_DATA_BITS-1:0] STEP_THRESHOLD_RESET = 8'd2;
    localparam logic [CFG_DATA_BITS-1:0] WINDOW_POLLS_RESET   = 8'd40;

    typedef struct packed {
        logic [POSITION_BITS-1:0] last_position;
        logic [COUNT_BITS-1:0]    up_steps;
        logic [COUNT_BITS-1:0]    down_steps;
        logic [AGE_BITS-1:0]      window_age;
    } trend_state_t;

endpackage

// ===== rtl/core/qrgd_in_if.sv =====
// Input channel carrying one phase sample and a poll strobe per transaction.
interface qrgd_in_if;
    logic valid;
    logic ready;
    logic phase_a;
    logic phase_b;
    logic poll;

    modport source (output valid, output phase_a, output phase_b, output poll, input ready);
    modport sink   (input valid, input phase_a, input phase_b, input poll, output ready);
endinterface

// ===== rtl/core/qrgd_out_if.sv =====
// Output channel carrying turn pulses and the running position per transaction.
interface qrgd_out_if;
    logic                valid;
    logic                ready;
    logic                right_turn;
    logic                left_turn;
    logic signed [15:0]  position;

    modport source (output valid, output right_turn, output left_turn, output position,
                    input ready);
    modport sink   (input valid, input right_turn, input left_turn, input position,
                    output ready);
endinterface

// ===== rtl/core/qrgd_trend.sv =====
// Trend evaluation at a poll: window aging, direction counts and turn detection.
module qrgd_trend (
    input  logic                                 poll,
    input  logic [qrgd_pkg::POSITION_BITS-1:0]   position,
    input  logic [qrgd_pkg::CFG_DATA_BITS-1:0]   step_threshold,
    input  logic [qrgd_pkg::CFG_DATA_BITS-1:0]   window_polls,
    input  qrgd_pkg::trend_state_t               trend_cur,
    output qrgd_pkg::trend_state_t               trend_new,
    output logic                                 right_turn,
    output logic                                 left_turn
);
    import qrgd_pkg::*;

    logic [POSITION_BITS-1:0] delta;
    logic [POSITION_BITS-1:0] mag;
    logic                     move_up;
    logic                     move_down;
    logic                     restart;
    logic [AGE_BITS-1:0]      age_inc;
    logic [AGE_BITS-1:0]      age_mid;
    logic [COUNT_BITS-1:0]    base_up;
    logic [COUNT_BITS-1:0]    base_down;
    logic [SUM_BITS-1:0]      sum;
    logic [COUNT_BITS-1:0]    sat;
    logic [COUNT_BITS-1:0]    up_mid;
    logic [COUNT_BITS-1:0]    down_mid;
    logic                     in_window;
    logic                     up_hit;
    logic                     down_hit;

    always_comb
    begin
        delta     = position - trend_cur.last_position;
        move_up   = (delta != '0) && !delta[POSITION_BITS-1];
        move_down = (delta != '0) && delta[POSITION_BITS-1];
        // The most negative change negates to itself, which is already its magnitude.
        mag       = move_up ? delta : (~delta + POSITION_BITS'(1));
        age_inc   = (trend_cur.window_age != AGE_MAX) ?
                    trend_cur.window_age + AGE_BITS'(1) : trend_cur.window_age;

        restart = 1'b0;
        if (move_up)
        begin
            restart = (trend_cur.up_steps == '0) || (trend_cur.down_steps != '0);
        end
        else if (move_down)
        begin
            restart = (trend_cur.down_steps == '0) || (trend_cur.up_steps != '0);
        end

        base_up   = restart ? '0 : trend_cur.up_steps;
        base_down = restart ? '0 : trend_cur.down_steps;
        age_mid   = restart ? '0 : age_inc;

        sum = SUM_BITS'(move_up ? base_up : base_down) + SUM_BITS'(mag);
        sat = (sum > SUM_BITS'(CNT_MAX)) ? CNT_MAX : sum[COUNT_BITS-1:0];

        up_mid   = move_up   ? sat : base_up;
        down_mid = move_down ? sat : base_down;

        in_window = (age_mid <= window_polls);
        up_hit    = CMP_BITS'(up_mid) >= CMP_BITS'(step_threshold);
        down_hit  = CMP_BITS'(down_mid) >= CMP_BITS'(step_threshold);

        trend_new  = trend_cur;
        right_turn = 1'b0;
        left_turn  = 1'b0;
        if (poll)
        begin
            trend_new.last_position = position;
            trend_new.window_age    = age_mid;
            trend_new.up_steps      = up_mid;
            trend_new.down_steps    = down_mid;
            if (in_window)
            begin
                if (up_hit)
                begin
                    right_turn         = 1'b1;
                    trend_new.up_steps = '0;
                end
                else if (down_hit)
                begin
                    left_turn            = 1'b1;
                    trend_new.down_steps = '0;
                end
            end
            else
            begin
                trend_new.up_steps   = '0;
                trend_new.down_steps = '0;
            end
        end
    end

endmodule

// ===== rtl/core/quadrature_rotation_gesture_detector_top.sv =====
// Top level of the quadrature rotation gesture detector.
//
// Each input transaction carries one sample of encoder phases A and B and a poll
// strobe, and produces exactly one output transaction with the right and left turn
// pulses and the running position after that sample. The block takes one sample per
// clock cycle while the output side does not stall. A sample passes through an input
// register and then a result register, which presents its result. A stalled output
// holds its result, and input ready drops only once the input register is full
// behind it. The edge decode and the trend evaluation both close their state loop
// within the single compute stage between those registers. Configuration writes
// (index 0 step threshold, index 1 window length in polls) take effect on the next
// cycle.
module quadrature_rotation_gesture_detector_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    qrgd_in_if.sink                                in_ch,
    qrgd_out_if.source                             out_ch,
    input  logic                                   cfg_we,
    input  logic [qrgd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [qrgd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import qrgd_pkg::*;

    logic                         hold_valid_reg;
    logic                         hold_a_reg;
    logic                         hold_b_reg;
    logic                         hold_poll_reg;

    logic                         out_valid_reg;
    logic                         out_right_reg;
    logic                         out_left_reg;
    logic [POSITION_OUT_BITS-1:0] out_position_reg;

    logic                         prev_a_reg;
    logic                         armed_reg;
    logic                         latched_b_reg;
    logic [POSITION_BITS-1:0]     position_reg;
    trend_state_t                 trend_reg;

    logic [CFG_DATA_BITS-1:0]     step_threshold_reg;
    logic [CFG_DATA_BITS-1:0]     window_polls_reg;

    logic                         armed_next;
    logic                         latched_b_next;
    logic [POSITION_BITS-1:0]     position_next;
    trend_state_t                 trend_next;
    logic                         right_next;
    logic                         left_next;
    logic [31:0]                  position_wide;

    logic                         advance;
    logic                         in_take;

    assign advance      = hold_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !hold_valid_reg || !out_valid_reg || out_ch.ready;
    assign in_take      = in_ch.valid && in_ch.ready;

    // A change of phase A is the edge event; rising arms, falling while armed disarms and steps if B changed.
    always_comb
    begin
        armed_next     = armed_reg;
        latched_b_next = latched_b_reg;
        position_next  = position_reg;
        if (hold_a_reg != prev_a_reg)
        begin
            if (hold_a_reg && !armed_reg)
            begin
                latched_b_next = hold_b_reg;
                armed_next     = 1'b1;
            end
            else if (!hold_a_reg && armed_reg)
            begin
                if (!hold_b_reg && latched_b_reg)
                begin
                    position_next = position_reg + POSITION_BITS'(1);
                end
                else if (hold_b_reg && !latched_b_reg)
                begin
                    position_next = position_reg - POSITION_BITS'(1);
                end
                armed_next = 1'b0;
            end
        end
    end

    qrgd_trend u_trend (
        .poll           (hold_poll_reg),
        .position       (position_next),
        .step_threshold (step_threshold_reg),
        .window_polls   (window_polls_reg),
        .trend_cur      (trend_reg),
        .trend_new      (trend_next),
        .right_turn     (right_next),
        .left_turn      (left_next)
    );

    assign position_wide = 32'(position_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
            prev_a_reg         <= 1'b0;
            armed_reg          <= 1'b0;
            latched_b_reg      <= 1'b0;
            position_reg       <= '0;
            trend_reg          <= '0;
            step_threshold_reg <= STEP_THRESHOLD_RESET;
            window_polls_reg   <= WINDOW_POLLS_RESET;
        end
        else
        begin
            if (in_take)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                prev_a_reg    <= hold_a_reg;
                armed_reg     <= armed_next;
                latched_b_reg <= latched_b_next;
                position_reg  <= position_next;
                trend_reg     <= trend_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STEP_THRESHOLD: step_threshold_reg <= cfg_data;
                    REG_WINDOW_POLLS:   window_polls_reg   <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hold_a_reg    <= in_ch.phase_a;
            hold_b_reg    <= in_ch.phase_b;
            hold_poll_reg <= in_ch.poll;
        end
        if (advance)
        begin
            out_right_reg    <= right_next;
            out_left_reg     <= left_next;
            out_position_reg <= position_wide[POSITION_OUT_BITS-1:0];
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.right_turn = out_right_reg;
    assign out_ch.left_turn  = out_left_reg;
    assign out_ch.position   = out_position_reg;

endmodule
